// File: sv/restoring_divider_128_assert.svh
// assertion macros for the 128-bit restoring divider
// used by the port checker, no other dependencies
`ifndef RESTORING_DIVIDER_128_ASSERT_SVH
`define RESTORING_DIVIDER_128_ASSERT_SVH

// same-cycle implication
`define RD128_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("rd128 port check failed");

// next-cycle implication
`define RD128_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("rd128 port check failed");

`endif

// File: sv/rd128_pkg.sv
// shared widths for the 128-bit restoring divider
// used by restoring_divider_128 and its port checker
package rd128_pkg;

  localparam int WORD_W = 64;
  localparam int DATA_W = 2 * WORD_W;
  localparam int CNT_W  = $clog2(DATA_W);

endpackage

// File: sv/restoring_divider_128.sv
// 128-bit unsigned restoring divider, one shared subtractor under a small sequencer
// depends on rd128_pkg
//
// One transfer in gives one transfer out. The divisor is first shifted left one bit
// per cycle while it still fits under the dividend (s shifts, 0 to 127), then s+1
// restoring subtract steps produce one quotient bit each. A zero divisor gives the result in
// the cycle after the input transfer: it sets divide_by_zero with quotient zero and
// remainder equal to the dividend. Both phases run on one 128-bit subtractor.
// The block takes no new input until the result has been transferred.
module restoring_divider_128 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [rd128_pkg::WORD_W-1:0] dividend_hi,
  input  logic [rd128_pkg::WORD_W-1:0] dividend_lo,
  input  logic [rd128_pkg::WORD_W-1:0] divisor_hi,
  input  logic [rd128_pkg::WORD_W-1:0] divisor_lo,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [rd128_pkg::WORD_W-1:0] quotient_hi,
  output logic [rd128_pkg::WORD_W-1:0] quotient_lo,
  output logic [rd128_pkg::WORD_W-1:0] remainder_hi,
  output logic [rd128_pkg::WORD_W-1:0] remainder_lo,
  output logic                        divide_by_zero
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALIGN = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam int DW = rd128_pkg::DATA_W;
  localparam int WW = rd128_pkg::WORD_W;

  logic [1:0]                    state;
  logic [DW-1:0]                 m;
  logic [DW-1:0]                 d;
  logic [DW-1:0]                 q;
  logic [rd128_pkg::CNT_W-1:0]   cnt;
  logic                          dz;

  logic [DW-1:0]                 sub_op;
  logic [DW-1:0]                 diff;
  logic                          borrow;
  logic                          ge;

  // shared subtractor: aligned probe in ALIGN, current divisor in DIV
  always_comb begin
    sub_op        = (state == ST_ALIGN) ? {d[DW-2:0], 1'b0} : d;
    {borrow, diff} = {1'b0, m} - {1'b0, sub_op};
    ge            = ~borrow;
  end

  assign req_ready      = (state == ST_IDLE);
  assign rsp_valid      = (state == ST_DONE);
  assign quotient_hi    = q[DW-1:WW];
  assign quotient_lo    = q[WW-1:0];
  assign remainder_hi   = m[DW-1:WW];
  assign remainder_lo   = m[WW-1:0];
  assign divide_by_zero = dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            if ({divisor_hi, divisor_lo} == '0) begin
              state <= ST_DONE;
            end else begin
              state <= ST_ALIGN;
            end
          end
        end
        ST_ALIGN: begin
          if (d[DW-1] || !ge) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        m   <= {dividend_hi, dividend_lo};
        d   <= {divisor_hi, divisor_lo};
        q   <= '0;
        cnt <= '0;
        dz  <= ({divisor_hi, divisor_lo} == '0);
      end
      ST_ALIGN: begin
        if (!d[DW-1] && ge) begin
          d   <= {d[DW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
        end
      end
      ST_DIV: begin
        if (ge) begin
          m <= diff;
        end
        q <= {q[DW-2:0], ge};
        d <= {1'b0, d[DW-1:1]};
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/rd128_check.sv
// port-level checker for restoring_divider_128, bound into restoring_divider_128
// depends on rd128_pkg and restoring_divider_128_assert.svh
`include "restoring_divider_128_assert.svh"

module rd128_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic [rd128_pkg::WORD_W-1:0] dividend_hi,
  input logic [rd128_pkg::WORD_W-1:0] dividend_lo,
  input logic [rd128_pkg::WORD_W-1:0] divisor_hi,
  input logic [rd128_pkg::WORD_W-1:0] divisor_lo,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [rd128_pkg::WORD_W-1:0] quotient_hi,
  input logic [rd128_pkg::WORD_W-1:0] quotient_lo,
  input logic [rd128_pkg::WORD_W-1:0] remainder_hi,
  input logic [rd128_pkg::WORD_W-1:0] remainder_lo,
  input logic                         divide_by_zero
);

  // no new input while a result waits
  `RD128_ASSERT_NOW(a_busy_on_result, rsp_valid, !req_ready)

  // busy right after an input transfer
  `RD128_ASSERT_NEXT(a_busy_after_in, req_valid && req_ready, !req_ready)

  // zero divisor gives the dividend back with a zero quotient
  `RD128_ASSERT_NEXT(a_div_zero,
    req_valid && req_ready && divisor_hi == '0 && divisor_lo == '0,
    rsp_valid && divide_by_zero && quotient_hi == '0 && quotient_lo == '0
      && remainder_hi == $past(dividend_hi) && remainder_lo == $past(dividend_lo))

  // stalled result holds
  `RD128_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
    rsp_valid && $stable(quotient_hi) && $stable(quotient_lo)
      && $stable(remainder_hi) && $stable(remainder_lo) && $stable(divide_by_zero))

endmodule

bind restoring_divider_128 rd128_check u_rd128_check (.*);

// File: dv/restoring_divider_128_test.sv
`timescale 1ns / 100ps
// self-checking bench for restoring_divider_128: corner divisions from a table, then random
// operand pairs checked against a shift-subtract quotient/remainder calculation
// depends on rd128_pkg and the restoring_divider_128 rtl
module restoring_divider_128_test;

  localparam int DATA_W = rd128_pkg::DATA_W;
  localparam int WORD_W = rd128_pkg::WORD_W;

  typedef logic [DATA_W-1:0] u128_t;

  typedef struct packed {
    u128_t quo;
    u128_t rem;
    logic  dz;
  } div_result_t;

  typedef struct packed {
    u128_t       num;
    u128_t       den;
    logic        typed;
    div_result_t want;
  } division_row_t;

  typedef enum int unsigned {RX_FREE, RX_RANDOM, RX_SPARSE} rx_mode_t;

  localparam u128_t MSB_ONLY  = u128_t'(1) << (DATA_W - 1);
  localparam u128_t BELOW_MSB = MSB_ONLY - 1;
  localparam u128_t WORD_ONES = u128_t'(64'hFFFF_FFFF_FFFF_FFFF);
  localparam u128_t HI_ONE    = u128_t'(1) << WORD_W;
  localparam int    N_RANDOM  = 2000;

  localparam division_row_t CORNER_DIVISIONS [18] = '{
    '{'0,        '0,        1'b1, '{'0,        '0,        1'b1}},
    '{'1,        '0,        1'b1, '{'0,        '1,        1'b1}},
    '{'0,        128'd1,    1'b1, '{'0,        '0,        1'b0}},
    '{'0,        '1,        1'b1, '{'0,        '0,        1'b0}},
    '{'1,        128'd1,    1'b1, '{'1,        '0,        1'b0}},
    '{'1,        '1,        1'b1, '{128'd1,    '0,        1'b0}},
    '{128'd1,    '1,        1'b1, '{'0,        128'd1,    1'b0}},
    '{128'd1,    128'd1,    1'b1, '{128'd1,    '0,        1'b0}},
    '{128'd5,    128'd7,    1'b1, '{'0,        128'd5,    1'b0}},
    '{128'd100,  128'd7,    1'b1, '{128'd14,   128'd2,    1'b0}},
    '{MSB_ONLY,  128'd1,    1'b1, '{MSB_ONLY,  '0,        1'b0}},
    '{MSB_ONLY,  MSB_ONLY,  1'b1, '{128'd1,    '0,        1'b0}},
    '{'1,        MSB_ONLY,  1'b1, '{128'd1,    BELOW_MSB, 1'b0}},
    '{BELOW_MSB, MSB_ONLY,  1'b1, '{'0,        BELOW_MSB, 1'b0}},
    '{'1,        HI_ONE,    1'b1, '{WORD_ONES, WORD_ONES, 1'b0}},
    '{128'hAAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA,
      128'h5555_5555_5555_5555, 1'b0, '{'0, '0, 1'b0}},
    '{128'hFEDC_BA98_7654_3210_0123_4567_89AB_CDEF,
      128'h3_0000_0000_0000_0001, 1'b0, '{'0, '0, 1'b0}},
    '{128'h1_0000_0000_0000_0000_0000_0000,
      WORD_ONES, 1'b0, '{'0, '0, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [WORD_W-1:0] dividend_hi = '0;
  logic [WORD_W-1:0] dividend_lo = '0;
  logic [WORD_W-1:0] divisor_hi = '0;
  logic [WORD_W-1:0] divisor_lo = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic [WORD_W-1:0] quotient_hi;
  logic [WORD_W-1:0] quotient_lo;
  logic [WORD_W-1:0] remainder_hi;
  logic [WORD_W-1:0] remainder_lo;
  logic divide_by_zero;

  div_result_t quotients_due[$];
  int unsigned errors = 0;
  int unsigned burst_left = 0;
  int unsigned n_checked = 0;
  int unsigned n_by_zero = 0;
  int unsigned n_zero_quo = 0;
  int unsigned n_wide_quo = 0;
  int unsigned rx_cycle = 0;
  rx_mode_t rx_mode = RX_FREE;

  restoring_divider_128 dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .dividend_hi(dividend_hi),
    .dividend_lo(dividend_lo),
    .divisor_hi(divisor_hi),
    .divisor_lo(divisor_lo),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .quotient_hi(quotient_hi),
    .quotient_lo(quotient_lo),
    .remainder_hi(remainder_hi),
    .remainder_lo(remainder_lo),
    .divide_by_zero(divide_by_zero)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int lead_zeros(u128_t v);
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (v[i]) return DATA_W - 1 - i;
    end
    return DATA_W;
  endfunction

  function automatic div_result_t long_divide(u128_t num, u128_t den);
    div_result_t r;
    u128_t d;
    int sh;
    r.quo = '0;
    r.rem = num;
    r.dz = (den == '0);
    if (!r.dz && lead_zeros(den) >= lead_zeros(num) && num >= den) begin
      sh = lead_zeros(den) - lead_zeros(num);
      d = den << sh;
      for (int i = 0; i <= sh; i++) begin
        r.quo = r.quo << 1;
        if (r.rem >= d) begin
          r.rem = r.rem - d;
          r.quo[0] = 1'b1;
        end
        d = d >> 1;
      end
    end
    return r;
  endfunction

  function automatic u128_t rand_bits();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic u128_t operand_corner();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return u128_t'(1) << $urandom_range(0, DATA_W - 1);
      default: return u128_t'('1) >> $urandom_range(0, DATA_W - 1);
    endcase
  endfunction

  task automatic pick_operands(output u128_t num, output u128_t den);
    case ($urandom_range(0, 3))
      0: num = rand_bits();
      1: num = rand_bits() >> $urandom_range(0, DATA_W - 1);
      2: num = rand_bits() >> $urandom_range(WORD_W, DATA_W - 1);
      default: num = operand_corner();
    endcase
    case ($urandom_range(0, 19))
      0: den = '0;
      1: den = num;
      2: den = num + $urandom_range(1, 1000);
      3: den = u128_t'(1) << $urandom_range(0, DATA_W - 1);
      4: den = operand_corner();
      default: den = rand_bits() >> $urandom_range(0, DATA_W - 1);
    endcase
  endtask

  task automatic send_division(input u128_t num, input u128_t den, input div_result_t want);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    req_valid <= 1'b1;
    {dividend_hi, dividend_lo} <= num;
    {divisor_hi, divisor_lo} <= den;
    do @(posedge clk); while (!req_ready);
    quotients_due.push_back(want);
  endtask

  task automatic drain_divider();
    req_valid <= 1'b0;
    burst_left = 0;
    while (quotients_due.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [WORD_W-1:0] want_v,
                                      logic [WORD_W-1:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endfunction

  // receiver stall pattern, mode drawn at random from free, random and sparse
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 2));
    case (rx_mode)
      RX_FREE: rsp_ready <= 1'b1;
      RX_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
      default: rsp_ready <= (rx_cycle % 5 == 4);
    endcase
  end

  always @(posedge clk) begin
    div_result_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (quotients_due.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing outstanding, expected none, got q=%0h r=%0h",
                 $time, {quotient_hi, quotient_lo}, {remainder_hi, remainder_lo});
      end else begin
        want = quotients_due.pop_front();
        check_field("quotient_hi", want.quo[DATA_W-1:WORD_W], quotient_hi);
        check_field("quotient_lo", want.quo[WORD_W-1:0], quotient_lo);
        check_field("remainder_hi", want.rem[DATA_W-1:WORD_W], remainder_hi);
        check_field("remainder_lo", want.rem[WORD_W-1:0], remainder_lo);
        check_field("divide_by_zero", WORD_W'(want.dz), WORD_W'(divide_by_zero));
        n_checked++;
        if (want.dz) n_by_zero++;
        else if (want.quo == '0) n_zero_quo++;
        if (want.quo[DATA_W-1:WORD_W] != '0) n_wide_quo++;
      end
    end
  end

  initial begin
    u128_t num;
    u128_t den;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (CORNER_DIVISIONS[i]) begin
      send_division(CORNER_DIVISIONS[i].num, CORNER_DIVISIONS[i].den,
                    CORNER_DIVISIONS[i].typed ? CORNER_DIVISIONS[i].want
                                              : long_divide(CORNER_DIVISIONS[i].num,
                                                            CORNER_DIVISIONS[i].den));
    end
    drain_divider();
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 500 == 250) drain_divider();
      pick_operands(num, den);
      send_division(num, den, long_divide(num, den));
    end
    drain_divider();
    repeat (300) @(posedge clk);
    $display("checked %0d divisions: %0d by zero, %0d with zero quotient,",
             n_checked, n_by_zero, n_zero_quo);
    $display("%0d with quotient >= 2^64", n_wide_quo);
    if (errors == 0) begin
      $display("restoring_divider_128_test: clean");
    end else begin
      $display("restoring_divider_128_test: errors");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("timeout with %0d results outstanding", quotients_due.size());
    $display("restoring_divider_128_test: errors");
    $finish;
  end

endmodule
